// ----- hdl/supply_reply_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Supply reply parser assertion macros
// Concurrent assertion wrappers for simulation; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_REPLY_PARSER_ASSERT_SVH
`define SUPPLY_REPLY_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// next-cycle implication
`define SRP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define SRP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define SRP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ----- hdl/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// Supply reply parser package
// Payload types, reply kind codes and character helpers.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int unsigned MAX_LINE_CHARS = 40;

	// line position thresholds (position = characters already taken)
	localparam logic [5:0] POS_MAX     = 6'd63;
	localparam logic [5:0] POS_OVERLONG = 6'(MAX_LINE_CHARS);
	localparam logic [5:0] POS_REPORT_MIN = 6'd14;

	localparam logic [7:0] CH_ACK     = 8'h41; // 'A'
	localparam logic [7:0] CH_REPORT  = 8'h52; // 'R'
	localparam logic [7:0] CH_VERSION = 8'h42; // 'B'
	localparam logic [7:0] CH_ERROR   = 8'h45; // 'E'
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_SIX     = 8'h36;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN = 3'd7;

	localparam logic [8:0] FAULT_MASK = 9'h17E;

	typedef enum logic [2:0] {
		KIND_ACK       = 3'd0,
		KIND_REPORT    = 3'd1,
		KIND_VERSION   = 3'd2,
		KIND_ERROR     = 3'd3,
		KIND_MALFORMED = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_char;
		logic       line_end;
	} chr_t;

	typedef struct packed {
		kind_t       reply_kind;
		logic [2:0]  error_code;
		logic        checksum_ok;
		logic [11:0] voltage_monitor;
		logic [11:0] current_monitor;
		logic [11:0] filament_monitor;
		logic [8:0]  status_flags;
		logic        fault_active;
		logic [15:0] version_number;
	} reply_t;

	// per-line state as seen after folding in the current body character
	typedef struct packed {
		logic [5:0]       pos;
		logic [7:0]       prev_char;
		logic [7:0]       body_sum;
		logic [7:0]       lead_char;
		logic [7:0]       code_char;
		logic [2:0][11:0] mon;
		logic [8:0]       status;
		logic [15:0]      version;
	} view_t;

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// non-hex characters count as zero
	function automatic logic [3:0] hex_value(logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (is_dec(c))
			v = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			v = 4'(c[2:0] + 3'd1) + 4'd8;
		return v;
	endfunction

endpackage

// ----- hdl/srp_line.sv -----
// ----------------------------------------------------------------------------
// Supply reply parser line state
// Two-character hold line, body sum, field capture and version accumulator.
// ----------------------------------------------------------------------------
module srp_line (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    ch,
	input  logic          last,
	output srp_pkg::view_t view
);
	import srp_pkg::*;

	logic [15:0]      held_q;
	logic [5:0]       pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       lead_q;
	logic [7:0]       code_q;
	logic [2:0][11:0] mon_q;
	logic [8:0]       status_q;
	logic [15:0]      version_q;
	logic             run_q;

	logic [7:0]  b;
	logic [3:0]  hx;
	logic [19:0] vnext;
	logic        run_d;
	view_t       upd;

	assign b  = held_q[15:8];
	assign hx = hex_value(b);
	assign vnext = 20'(version_q) * 20'd10 + {16'd0, b[3:0]};

	// fold the character leaving the hold line into the body
	always_comb begin
		upd.pos       = pos_q;
		upd.prev_char = held_q[7:0];
		upd.body_sum  = sum_q;
		upd.lead_char = lead_q;
		upd.code_char = code_q;
		upd.mon       = mon_q;
		upd.status    = status_q;
		upd.version   = version_q;
		run_d         = run_q;
		if (pos_q >= 6'd2) begin
			upd.body_sum = sum_q + b;
			if (pos_q == 6'd2)
				upd.lead_char = b;
			if (pos_q == 6'd3)
				upd.code_char = b;
			case (pos_q) inside
				[6'd3:6'd5]:   upd.mon[0] = {mon_q[0][7:0], hx};
				[6'd6:6'd8]:   upd.mon[1] = {mon_q[1][7:0], hx};
				[6'd9:6'd11]:  upd.mon[2] = {mon_q[2][7:0], hx};
				6'd12:         upd.status = {hx, status_q[4:0]};
				6'd13:         upd.status = {status_q[8:5], hx, status_q[0]};
				6'd14:         upd.status = {status_q[8:1], hx[0]};
				default:       ;
			endcase
			if (pos_q >= 6'd3 && run_q) begin
				if (is_dec(b))
					upd.version = (vnext > 20'd65535) ? 16'hFFFF : vnext[15:0];
				else
					run_d = 1'b0;
			end
		end
	end

	assign view = upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			lead_q    <= '0;
			code_q    <= '0;
			mon_q     <= '0;
			status_q  <= '0;
			version_q <= '0;
			run_q     <= 1'b1;
		end else if (take) begin
			if (last) begin
				held_q    <= '0;
				pos_q     <= '0;
				sum_q     <= '0;
				lead_q    <= '0;
				code_q    <= '0;
				mon_q     <= '0;
				status_q  <= '0;
				version_q <= '0;
				run_q     <= 1'b1;
			end else begin
				held_q    <= {held_q[7:0], ch};
				pos_q     <= (pos_q == POS_MAX) ? pos_q : pos_q + 6'd1;
				sum_q     <= upd.body_sum;
				lead_q    <= upd.lead_char;
				code_q    <= upd.code_char;
				mon_q     <= upd.mon;
				status_q  <= upd.status;
				version_q <= upd.version;
				run_q     <= run_d;
			end
		end
	end

endmodule

// ----- hdl/supply_reply_parser.sv -----
// ----------------------------------------------------------------------------
// Supply reply parser
// Decodes one reply line of a high-voltage supply into a reply record.
// ----------------------------------------------------------------------------
//   channel | signals                          | transfer moves
//   --------+----------------------------------+-----------------------------
//   chr     | chr_valid, chr_ready, chr        | one line character + end mark
//   reply   | reply_valid, reply_ready, reply  | one decoded reply per line
//
// A character transfer lands in the input register; from there it is folded
// into the line state and, on the final character, loads the reply register.
// One character per cycle sustained unless a stalled reply holds a line end;
// reply_valid rises once the final character moves from input to reply register.
// Reset (arst_n low) clears the line state, both valid flags and all counters.
// A stalled reply holds only the final character of the next line; any
// other character keeps flowing into the line state.
// ----------------------------------------------------------------------------
`include "supply_reply_parser_assert.svh"

module supply_reply_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            chr_valid,
	output logic            chr_ready,
	input  srp_pkg::chr_t   chr,
	output logic            reply_valid,
	input  logic            reply_ready,
	output srp_pkg::reply_t reply
);
	import srp_pkg::*;

	logic   valid_s1;
	chr_t   chr_s1;
	logic   adv_s1;
	logic   load;
	view_t  view;
	reply_t rep_d;
	reply_t reply_q;
	logic   reply_valid_q;
	logic   ck_ok;
	logic   is_report;
	logic   is_version;

	// advance the input stage unless it holds a line end facing a full reply
	assign adv_s1    = valid_s1 && (!chr_s1.line_end || !reply_valid_q || reply_ready);
	assign chr_ready = !valid_s1 || adv_s1;
	assign load      = adv_s1 && chr_s1.line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (chr_ready)
			valid_s1 <= chr_valid;
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (chr_valid && chr_ready)
			chr_s1 <= chr;
	end

	srp_line u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv_s1),
		.ch     (chr_s1.rx_char),
		.last   (chr_s1.line_end),
		.view   (view)
	);

	// checksum: last two characters as a hex byte against the body sum
	assign ck_ok = (view.pos >= 6'd1) &&
		({hex_value(view.prev_char), hex_value(chr_s1.rx_char)} == view.body_sum);

	// classify the line
	always_comb begin
		rep_d             = '0;
		rep_d.checksum_ok = ck_ok;
		rep_d.reply_kind  = KIND_MALFORMED;
		rep_d.error_code  = ERR_NONE;
		if (view.pos >= 6'd2 && view.pos < POS_OVERLONG) begin
			case (view.lead_char)
				CH_ACK:    rep_d.reply_kind = KIND_ACK;
				CH_REPORT: begin
					if (view.pos >= POS_REPORT_MIN)
						rep_d.reply_kind = KIND_REPORT;
				end
				CH_VERSION: begin
					if (view.pos >= 6'd3 && is_dec(view.code_char))
						rep_d.reply_kind = KIND_VERSION;
				end
				CH_ERROR: begin
					rep_d.reply_kind = KIND_ERROR;
					if (view.pos >= 6'd3 && view.code_char >= CH_ONE
							&& view.code_char <= CH_SIX)
						rep_d.error_code = view.code_char[2:0];
					else
						rep_d.error_code = ERR_UNKNOWN;
				end
				default: ;
			endcase
		end
		is_report  = (rep_d.reply_kind == KIND_REPORT);
		is_version = (rep_d.reply_kind == KIND_VERSION);
		// zero the fields that do not belong to this kind
		if (is_report) begin
			rep_d.voltage_monitor  = view.mon[0];
			rep_d.current_monitor  = view.mon[1];
			rep_d.filament_monitor = view.mon[2];
			rep_d.status_flags     = view.status;
			rep_d.fault_active     = |(view.status & FAULT_MASK);
		end
		if (is_version)
			rep_d.version_number = view.version;
	end

	// reply register: load on a line end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			reply_valid_q <= 1'b0;
		else if (load)
			reply_valid_q <= 1'b1;
		else if (reply_ready)
			reply_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			reply_q <= rep_d;
	end

	assign reply_valid = reply_valid_q;
	assign reply       = reply_q;

	`SRP_ASSERT_IMP(a_reply_from_line_end, clk, arst_n, $rose(reply_valid_q), $past(load), "reply raised without a line end")
	`SRP_ASSERT_NXT(a_pos_clear, clk, arst_n, load, view.pos == 6'd0, "line position not cleared after line end")
	`SRP_ASSERT_IMP(a_report_fields, clk, arst_n, reply_valid_q && reply_q.reply_kind != KIND_REPORT, reply_q.status_flags == 9'd0 && !reply_q.fault_active && reply_q.voltage_monitor == 12'd0, "report fields set on a non-report reply")
	`SRP_ASSERT_IMP(a_error_code, clk, arst_n, reply_valid_q && reply_q.reply_kind != KIND_ERROR, reply_q.error_code == ERR_NONE, "error code set on a non-error reply")
	`SRP_ASSERT_IMP(a_no_overwrite, clk, arst_n, reply_valid_q && !reply_ready, !load, "reply overwritten while stalled")

endmodule
